>>> sv/vu_meter_peak_bar_runs_top_defines.svh
// ---------------------------------------------------------------------------
// VU meter peak bar runs: assertion macros
// Shared assertion macros for the meter block. Define ASSERT_OFF to compile
// every assertion away.
// ---------------------------------------------------------------------------
`ifndef VU_METER_PEAK_BAR_RUNS_TOP_DEFINES_SVH
`define VU_METER_PEAK_BAR_RUNS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define VU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// An implication checked in the same cycle outside reset.
`define VU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define VU_ASSERT(lbl, prop, msg)
`define VU_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

>>> sv/vmpb_pkg.sv
// ---------------------------------------------------------------------------
// VU meter peak bar runs: package
// Types, constants and the control program shared by the sequencer and the
// datapath of the meter block.
// ---------------------------------------------------------------------------
package vmpb_pkg;

    // Register indexes on the configuration channel.
    typedef enum logic [2:0] {
        REG_GREEN_DIM     = 3'd0,
        REG_GREEN_BRIGHT  = 3'd1,
        REG_YELLOW_DIM    = 3'd2,
        REG_YELLOW_BRIGHT = 3'd3,
        REG_RED_DIM       = 3'd4,
        REG_RED_BRIGHT    = 3'd5,
        REG_PEAK_MARKER   = 3'd6,
        REG_DECAY         = 3'd7
    } reg_idx_t;

    localparam int NUM_COLORS = 7;
    localparam int DECAY_W    = 11;

    // Reset values of the seven colour registers, in index order.
    localparam logic [15:0] COLOR_RESET [NUM_COLORS] = '{
        16'd14979, 16'd26560, 16'd23011, 16'd65088, 16'd22691, 16'd63488, 16'd65503
    };
    localparam logic [DECAY_W-1:0] DECAY_RESET = 11'd192;

    // Colour zones of a bar row; {zone, lit} gives the colour register index.
    typedef enum logic [1:0] {
        ZONE_GREEN  = 2'd0,
        ZONE_YELLOW = 2'd1,
        ZONE_RED    = 2'd2
    } zone_t;

    // Level mapping and peak hold constants (signed Q8.8 dB).
    localparam logic [11:0]        MV_OFFSET    = 12'd1100;
    localparam logic [19:0]        LEVEL_RECIP  = 20'd639132;
    localparam logic signed [15:0] LEVEL_OFFSET = -16'sd15104;
    localparam logic signed [15:0] PEAK_RESET   = -16'sd15360;
    localparam logic signed [15:0] PEAK_FLOOR   = -16'sd14848;

    // Datapath operations of one control word.
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_MUL,
        OP_LEVEL,
        OP_PEAK,
        OP_SETUP,
        OP_ROW,
        OP_FLUSH,
        OP_EMIT
    } op_t;

    // Jump conditions; when true the sequencer goes to the target step.
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_ROWS_MORE,
        COND_EMIT_BUSY
    } cond_t;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Status flags from the datapath that the jump conditions test.
    typedef struct packed {
        logic no_input;
        logic rows_more;
        logic emit_busy;
    } status_t;

    // The control program. The step after the last one wraps to the first.
    function automatic ctrl_word_t rom_word(input step_t step);
        ctrl_word_t w;
        unique case (step)
            3'd0:    w = '{op: OP_WAIT,  cond: COND_NO_INPUT,  target: 3'd0};
            3'd1:    w = '{op: OP_MUL,   cond: COND_NEVER,     target: 3'd0};
            3'd2:    w = '{op: OP_LEVEL, cond: COND_NEVER,     target: 3'd0};
            3'd3:    w = '{op: OP_PEAK,  cond: COND_NEVER,     target: 3'd0};
            3'd4:    w = '{op: OP_SETUP, cond: COND_NEVER,     target: 3'd0};
            3'd5:    w = '{op: OP_ROW,   cond: COND_ROWS_MORE, target: 3'd5};
            3'd6:    w = '{op: OP_FLUSH, cond: COND_NEVER,     target: 3'd0};
            3'd7:    w = '{op: OP_EMIT,  cond: COND_EMIT_BUSY, target: 3'd7};
            default: w = '{op: OP_WAIT,  cond: COND_NO_INPUT,  target: 3'd0};
        endcase
        return w;
    endfunction

endpackage

>>> sv/vmpb_seq.sv
// ---------------------------------------------------------------------------
// VU meter peak bar runs: sequencer
// Step counter over the control program, with conditional jumps on the
// datapath status.
// ---------------------------------------------------------------------------
module vmpb_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vmpb_pkg::status_t    status,
    output vmpb_pkg::ctrl_word_t ctrl
);

    vmpb_pkg::step_t step_reg;
    vmpb_pkg::step_t step_next;
    logic            take_jump;

    // Control word of the current step.
    always_comb
    begin
        ctrl = vmpb_pkg::rom_word(step_reg);
    end

    // Jump condition and next step.
    always_comb
    begin
        unique case (ctrl.cond)
            vmpb_pkg::COND_NEVER:     take_jump = 1'b0;
            vmpb_pkg::COND_NO_INPUT:  take_jump = status.no_input;
            vmpb_pkg::COND_ROWS_MORE: take_jump = status.rows_more;
            vmpb_pkg::COND_EMIT_BUSY: take_jump = status.emit_busy;
            default:                  take_jump = 1'b0;
        endcase
        step_next = take_jump ? ctrl.target : vmpb_pkg::STEP_W'(step_reg + 1'b1);
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

>>> sv/vu_meter_peak_bar_runs_top.sv
// ---------------------------------------------------------------------------
// VU meter peak bar runs: top level
// Maps a millivolt sample to a dB level, updates the bar's peak hold and
// streams the bar as run-length colour runs.
// ---------------------------------------------------------------------------
// One sample is taken at a time. The microcoded sequencer spends five steps on
// the level and peak arithmetic (acceptance included), then scans the BAR_HEIGHT-6
// rows of the bar one row a cycle, spends one step closing the last run and one
// step per emitted run, each held while the output stalls. The next sample is
// accepted as soon as the last run has been loaded into the output register.
`include "vu_meter_peak_bar_runs_top_defines.svh"

module vu_meter_peak_bar_runs_top #(
    parameter int BAR_HEIGHT = 128,
    parameter int BAR_TOP    = 5,
    parameter int MAX_RUNS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Sample input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample_mv, [15:12] zero
    input  logic [0:0]  s_axis_tuser,   // [0] channel
    // Run output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] run_top_row, [14:8] run_rows,
                                        // [30:15] run_color, [45:31] level_db,
                                        // [60:46] peak_db, [63:61] zero
    output logic [0:0]  m_axis_tuser,   // [0] bar_channel
    output logic        m_axis_tlast,   // last_run
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ROWS   = BAR_HEIGHT - 6;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int LEN_W  = ($clog2(ROWS + 1) > 7) ? $clog2(ROWS + 1) : 7;
    localparam int CNT_W  = $clog2(MAX_RUNS + 1);
    localparam int IDX_W  = $clog2(MAX_RUNS);
    localparam int ACC_W  = $clog2(ROWS) + 17;

    // Row thresholds, all scaled by the row count.
    localparam logic signed [ACC_W-1:0] VQ_START = ACC_W'(5120 * ROWS);
    localparam logic signed [ACC_W-1:0] VQ_STEP  = ACC_W'(20480);
    localparam logic signed [ACC_W-1:0] PEAK_TOL = ACC_W'(128 * ROWS);
    localparam logic signed [ACC_W-1:0] NEG_TOL  = ACC_W'(-128 * ROWS);
    localparam logic signed [ACC_W-1:0] YEL_LIM  = ACC_W'(1024 * ROWS);
    localparam logic signed [ACC_W-1:0] ACC_ZERO = ACC_W'(0);
    localparam logic [CNT_W-1:0]        CNT_MAX  = CNT_W'(MAX_RUNS);
    localparam logic [7:0]              TOP_BASE = 8'(BAR_TOP + 3);

    vmpb_pkg::ctrl_word_t ctrl;
    vmpb_pkg::status_t    status;

    // Configuration registers.
    logic [15:0]                  color_reg [vmpb_pkg::NUM_COLORS];
    logic [vmpb_pkg::DECAY_W-1:0] decay_reg;

    // Sample, level and peak.
    logic                     ch_reg;
    logic [11:0]              mv_reg;
    logic [11:0]              mv_excess;
    logic [31:0]              prod_reg;
    logic signed [15:0]       level_reg;
    logic signed [15:0]       peak_reg;
    logic signed [15:0]       peak_hold_reg [2];
    logic signed [15:0]       peak_old;
    logic signed [16:0]       peak_dec;
    logic signed [16:0]       floor_ext;
    logic signed [15:0]       peak_decayed;
    logic signed [15:0]       peak_next;
    logic signed [ACC_W-1:0]  lvl_r_reg;
    logic signed [ACC_W-1:0]  pk_r_reg;

    // Row scan.
    logic signed [ACC_W-1:0]  vq_reg;
    logic signed [ACC_W-1:0]  diff;
    logic [ROW_W-1:0]         rows_left_reg;
    logic [7:0]               row_top_reg;
    logic                     row_is_peak;
    logic                     row_lit;
    vmpb_pkg::zone_t          row_zone;
    logic [2:0]               row_col_idx;
    logic [15:0]              row_col;
    logic [15:0]              marker;

    // Runs: the open run in registers, closed runs in a small register file.
    logic [CNT_W-1:0]         run_cnt_reg;
    logic [CNT_W-1:0]         run_cnt_next;
    logic [7:0]               cur_top_reg;
    logic [7:0]               cur_top_next;
    logic [LEN_W-1:0]         cur_len_reg;
    logic [LEN_W-1:0]         cur_len_next;
    logic [15:0]              cur_col_reg;
    logic [15:0]              cur_col_next;
    logic                     open_run;
    logic [15:0]              open_col;
    logic                     arr_we;
    logic [IDX_W-1:0]         arr_waddr;
    logic [7:0]               run_top_arr [MAX_RUNS];
    logic [LEN_W-1:0]         run_len_arr [MAX_RUNS];
    logic [15:0]              run_col_arr [MAX_RUNS];

    // Output register.
    logic [IDX_W-1:0]         emit_idx_reg;
    logic                     emit_fire;
    logic                     emit_last;
    logic                     out_valid_reg;
    logic                     out_ch_reg;
    logic [7:0]               out_top_reg;
    logic [6:0]               out_rows_reg;
    logic [15:0]              out_color_reg;
    logic signed [15:0]       out_level_reg;
    logic signed [15:0]       out_peak_reg;
    logic                     out_last_reg;

    // Sequencer.
    vmpb_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign status.no_input  = !s_axis_tvalid;
    assign status.rows_more = (rows_left_reg != '0);
    assign status.emit_busy = !(emit_fire && emit_last);

    assign s_axis_tready = (ctrl.op == vmpb_pkg::OP_WAIT);
    assign cfg_ready     = 1'b1;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vmpb_pkg::NUM_COLORS; i++)
            begin
                color_reg[i] <= vmpb_pkg::COLOR_RESET[i];
            end
            decay_reg <= vmpb_pkg::DECAY_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == vmpb_pkg::REG_DECAY)
            begin
                decay_reg <= cfg_data[vmpb_pkg::DECAY_W-1:0];
            end
            else
            begin
                color_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // Level offset and peak hold update.
    always_comb
    begin
        mv_excess    = (mv_reg > vmpb_pkg::MV_OFFSET) ? (mv_reg - vmpb_pkg::MV_OFFSET) : 12'd0;
        peak_old     = peak_hold_reg[ch_reg];
        peak_dec     = {peak_old[15], peak_old} - $signed({6'd0, decay_reg});
        floor_ext    = {vmpb_pkg::PEAK_FLOOR[15], vmpb_pkg::PEAK_FLOOR};
        peak_decayed = (peak_dec < floor_ext) ? vmpb_pkg::PEAK_FLOOR : peak_dec[15:0];
        if (level_reg > peak_old)
        begin
            peak_next = level_reg;
        end
        else if (peak_old > vmpb_pkg::PEAK_FLOOR)
        begin
            peak_next = (level_reg > peak_decayed) ? level_reg : peak_decayed;
        end
        else
        begin
            peak_next = peak_old;
        end
    end

    // Classification of the current row.
    always_comb
    begin
        diff        = vq_reg - pk_r_reg;
        row_is_peak = (diff <= PEAK_TOL) && (diff >= NEG_TOL);
        row_lit     = (lvl_r_reg >= vq_reg);
        if (vq_reg <= ACC_ZERO)
        begin
            row_zone = vmpb_pkg::ZONE_GREEN;
        end
        else if (vq_reg <= YEL_LIM)
        begin
            row_zone = vmpb_pkg::ZONE_YELLOW;
        end
        else
        begin
            row_zone = vmpb_pkg::ZONE_RED;
        end
        row_col_idx = {row_zone, row_lit};
        row_col     = color_reg[row_col_idx];
        marker      = color_reg[vmpb_pkg::REG_PEAK_MARKER];
    end

    // Run building: extend the open run or open a new one.
    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        cur_top_next = cur_top_reg;
        cur_len_next = cur_len_reg;
        cur_col_next = cur_col_reg;
        open_run     = 1'b0;
        open_col     = row_col;
        arr_we       = 1'b0;
        arr_waddr    = IDX_W'(run_cnt_reg - 1'b1);
        unique case (ctrl.op)
            vmpb_pkg::OP_SETUP:
            begin
                run_cnt_next = '0;
            end
            vmpb_pkg::OP_ROW:
            begin
                if (row_is_peak && ((run_cnt_reg == '0) || (cur_col_reg != marker)))
                begin
                    open_run = 1'b1;
                    open_col = marker;
                end
                else if ((run_cnt_reg != '0) && (cur_col_reg == row_col))
                begin
                    cur_len_next = LEN_W'(cur_len_reg + 1'b1);
                end
                else
                begin
                    open_run = 1'b1;
                end
                // Once the run list is full the last run takes the row.
                if (open_run)
                begin
                    if (run_cnt_reg < CNT_MAX)
                    begin
                        arr_we       = (run_cnt_reg != '0);
                        cur_top_next = row_top_reg;
                        cur_len_next = LEN_W'(1);
                        cur_col_next = open_col;
                        run_cnt_next = CNT_W'(run_cnt_reg + 1'b1);
                    end
                    else
                    begin
                        cur_len_next = LEN_W'(cur_len_reg + 1'b1);
                    end
                end
            end
            vmpb_pkg::OP_FLUSH:
            begin
                arr_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Output beat loading.
    assign emit_fire = (ctrl.op == vmpb_pkg::OP_EMIT) && (!out_valid_reg || m_axis_tready);
    assign emit_last = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == run_cnt_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg      <= '0;
            rows_left_reg    <= '0;
            emit_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
            peak_hold_reg[0] <= vmpb_pkg::PEAK_RESET;
            peak_hold_reg[1] <= vmpb_pkg::PEAK_RESET;
        end
        else
        begin
            run_cnt_reg <= run_cnt_next;
            if (ctrl.op == vmpb_pkg::OP_PEAK)
            begin
                peak_hold_reg[ch_reg] <= peak_next;
            end
            if (ctrl.op == vmpb_pkg::OP_SETUP)
            begin
                rows_left_reg <= ROW_W'(ROWS - 1);
            end
            else if (ctrl.op == vmpb_pkg::OP_ROW)
            begin
                rows_left_reg <= ROW_W'(rows_left_reg - 1'b1);
            end
            if (ctrl.op == vmpb_pkg::OP_FLUSH)
            begin
                emit_idx_reg <= '0;
            end
            else if (emit_fire)
            begin
                emit_idx_reg <= IDX_W'(emit_idx_reg + 1'b1);
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, one operation per control word.
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            vmpb_pkg::OP_WAIT:
            begin
                if (s_axis_tvalid)
                begin
                    ch_reg <= s_axis_tuser[0];
                    mv_reg <= s_axis_tdata[11:0];
                end
            end
            vmpb_pkg::OP_MUL:
            begin
                prod_reg <= {20'd0, mv_excess} * {12'd0, vmpb_pkg::LEVEL_RECIP};
            end
            vmpb_pkg::OP_LEVEL:
            begin
                level_reg <= $signed({1'b0, prod_reg[30:16]}) + vmpb_pkg::LEVEL_OFFSET;
            end
            vmpb_pkg::OP_PEAK:
            begin
                peak_reg  <= peak_next;
                lvl_r_reg <= ACC_W'(level_reg * ROWS);
            end
            vmpb_pkg::OP_SETUP:
            begin
                pk_r_reg    <= ACC_W'(peak_reg * ROWS);
                vq_reg      <= VQ_START;
                row_top_reg <= TOP_BASE;
            end
            vmpb_pkg::OP_ROW:
            begin
                vq_reg      <= vq_reg - VQ_STEP;
                row_top_reg <= 8'(row_top_reg + 1'b1);
            end
            default:
            begin
            end
        endcase
        cur_top_reg <= cur_top_next;
        cur_len_reg <= cur_len_next;
        cur_col_reg <= cur_col_next;
        if (arr_we)
        begin
            run_top_arr[arr_waddr] <= cur_top_reg;
            run_len_arr[arr_waddr] <= cur_len_reg;
            run_col_arr[arr_waddr] <= cur_col_reg;
        end
        if (emit_fire)
        begin
            out_ch_reg    <= ch_reg;
            out_top_reg   <= run_top_arr[emit_idx_reg];
            out_rows_reg  <= run_len_arr[emit_idx_reg][6:0];
            out_color_reg <= run_col_arr[emit_idx_reg];
            out_level_reg <= level_reg;
            out_peak_reg  <= peak_reg;
            out_last_reg  <= emit_last;
        end
    end

    // Output ports.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_peak_reg[14:0], out_level_reg[14:0], out_color_reg,
                            out_rows_reg, out_top_reg};
    assign m_axis_tuser  = out_ch_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks.
    `VU_ASSERT(a_run_count_bound, run_cnt_reg <= CNT_MAX, "run count above the run limit")
    `VU_ASSERT_IMP(a_peak_not_below_level, ctrl.op == vmpb_pkg::OP_ROW, peak_reg >= level_reg, "peak hold below level during scan")
    `VU_ASSERT_IMP(a_scan_only_last_pending, (ctrl.op == vmpb_pkg::OP_ROW) && out_valid_reg, out_last_reg, "non-final run still pending during scan")

endmodule
